// File: rtl/core/assert_macros.svh
// Assertion macros shared by the volume sampler RTL.
// Expects a clock named clock and a synchronous active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/core/tvs_pkg.sv
// Shared types, constants and the interpolation step plan of the volume sampler.
// No dependencies; used by every module under rtl/core.
package tvs_pkg;

   // field widths fixed by the word layout
   localparam int POS_W      = 18;
   localparam int ORG_W      = 9;
   localparam int EXT_W      = 6;
   localparam int DENS_W     = 16;
   localparam int CELL_W     = 15;
   localparam int IDX_W      = 21;   // holds any flat index and any store depth
   localparam int ROW_W      = 2 * EXT_W;
   localparam int PLANE_W    = 2 * EXT_W;
   localparam int PZ_W       = EXT_W + PLANE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int SLOT_W     = 3;    // eight corner slots

   // request word layout, lowest bit first
   localparam int CELL_LSB   = 0;
   localparam int DENS_LSB   = CELL_LSB + CELL_W;
   localparam int POSX_LSB   = DENS_LSB + DENS_W;
   localparam int POSY_LSB   = POSX_LSB + POS_W;
   localparam int POSZ_LSB   = POSY_LSB + POS_W;
   localparam int REQ_DATA_W = ((POSZ_LSB + POS_W + 7) / 8) * 8;

   localparam int MAX_CELLS_DEF = 32768;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [DENS_W-1:0] DENSITY_ONE = 16'd32768;
   localparam logic [EXT_W-1:0]  EXT_RESET   = 6'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORG_X = 3'd0,
      CSR_ORG_Y = 3'd1,
      CSR_ORG_Z = 3'd2,
      CSR_EXT_X = 3'd3,
      CSR_EXT_Y = 3'd4,
      CSR_EXT_Z = 3'd5
   } csr_reg_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LERP
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic en;
      logic we;
   } mem_ctl_type;

   typedef struct packed {
      logic [SLOT_W-1:0] a_slot;
      logic [SLOT_W-1:0] b_slot;
      logic [SLOT_W-1:0] dst_slot;
      axis_type          axis;
   } plan_type;

   localparam logic [SLOT_W-1:0] LAST_STEP = 3'd6;

   // Seven lerps: four along x, two along y, one along z. Results overwrite
   // the lower slot of each pair so the corner slots double as scratch.
   function automatic plan_type lerp_plan(input logic [SLOT_W-1:0] step);
      plan_type p;
      case (step)
         3'd0:    p = '{a_slot: 3'd0, b_slot: 3'd1, dst_slot: 3'd0, axis: AXIS_X};
         3'd1:    p = '{a_slot: 3'd2, b_slot: 3'd3, dst_slot: 3'd2, axis: AXIS_X};
         3'd2:    p = '{a_slot: 3'd4, b_slot: 3'd5, dst_slot: 3'd4, axis: AXIS_X};
         3'd3:    p = '{a_slot: 3'd6, b_slot: 3'd7, dst_slot: 3'd6, axis: AXIS_X};
         3'd4:    p = '{a_slot: 3'd0, b_slot: 3'd2, dst_slot: 3'd0, axis: AXIS_Y};
         3'd5:    p = '{a_slot: 3'd4, b_slot: 3'd6, dst_slot: 3'd4, axis: AXIS_Y};
         default: p = '{a_slot: 3'd0, b_slot: 3'd4, dst_slot: 3'd0, axis: AXIS_Z};
      endcase
      return p;
   endfunction

endpackage

// File: rtl/core/tvs_store.sv
// Single-port density store with a registered read port.
// Depends on tvs_pkg for the density width and the port control struct.
module tvs_store #(
   parameter int DEPTH = tvs_pkg::MAX_CELLS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  tvs_pkg::mem_ctl_type        ctl,
   input  logic [AW-1:0]               addr,
   input  logic [tvs_pkg::DENS_W-1:0]  wdata,
   output logic [tvs_pkg::DENS_W-1:0]  rdata
);
   import tvs_pkg::*;

   logic [DENS_W-1:0] mem [DEPTH];
   logic [DENS_W-1:0] rd_data_ff;

   // one access a cycle: write or read
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.we) begin
            mem[addr] <= wdata;
         end else begin
            rd_data_ff <= mem[addr];
         end
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/core/tvs_lerp.sv
// One rounded linear interpolation step between two densities.
// Depends on tvs_pkg for the density width.
module tvs_lerp #(
   parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
   input  logic [tvs_pkg::DENS_W-1:0] a,
   input  logic [tvs_pkg::DENS_W-1:0] b,
   input  logic [FRAC_BITS-1:0]       f,
   output logic [tvs_pkg::DENS_W-1:0] y
);
   import tvs_pkg::*;

   localparam int PW = DENS_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] HALF =
      {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   logic [FRAC_BITS:0] wf;
   logic [PW-1:0]      pa;
   logic [PW-1:0]      pb;
   logic [PW-1:0]      sum;

   assign wf  = FRAC_ONE - {1'b0, f};
   assign pa  = {{(PW - DENS_W){1'b0}}, a} * {{(PW - FRAC_BITS - 1){1'b0}}, wf};
   assign pb  = {{(PW - DENS_W){1'b0}}, b} * {{(PW - FRAC_BITS){1'b0}}, f};
   // ties round up; result stays between a and b
   assign sum = pa + pb + HALF;
   assign y   = sum[FRAC_BITS +: DENS_W];

endmodule

// File: rtl/core/trilinear_volume_sampler.sv
// Trilinear volume sampler: density store, corner fetch sequencer, lerp chain.
// Depends on tvs_pkg, tvs_store, tvs_lerp and assert_macros.svh.
//
// Usage:
//  req_*  : request words. tuser = op (write a cell / sample). A write stores
//           density_in (clamped to 1.0) at cell_addr; addresses beyond the
//           store are dropped. A sample returns one word on rsp_*.
//  rsp_*  : one 16-bit interpolated density per sample, held in an output
//           register until taken.
//  csr_*  : register writes (origin and extent per axis), taken every cycle;
//           write them only while no sample is in flight.
// Timing: writes are taken back to back. A sample holds req_tready low until its
//  result is handed to the output register, so a new sample is not taken before
//  the last is through: it fetches the eight corners through the single store
//  port (one read a cycle plus a two-stage index pipe), then runs the shared lerp
//  unit over the corner slots. The final lerp is registered and drives rsp_tvalid.
// Reset: clears the sequencer, the output valid and the registers (origins 0,
//  extents 32). Store contents are undefined until written; no clearing pass.
// Stall: if rsp_tready stays low, hold the finished result; writes carry on
//  until the next sample is taken, which runs through its fetch and holds the
//  request side at its last lerp step until the output register frees.
`include "assert_macros.svh"

module trilinear_volume_sampler #(
   parameter int MAX_CELLS = tvs_pkg::MAX_CELLS_DEF,
   parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cell_addr, density_in, pos_x, pos_y, pos_z, zero fill
   input  logic [tvs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // density_out
   output logic [tvs_pkg::DENS_W-1:0]       rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tvs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tvs_pkg::*;

   localparam int AW = $clog2(MAX_CELLS);
   localparam int GW = ((POS_W > ORG_W + FRAC_BITS) ? POS_W : ORG_W + FRAC_BITS) + 2;
   localparam int BW = GW - FRAC_BITS;
   localparam logic [GW-1:0] HALF_CELL =
      {{(GW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic [IDX_W-1:0] CELL_LIMIT = IDX_W'(MAX_CELLS);
   localparam logic [3:0] FETCH_LAST = 4'd9;

   // configuration
   logic signed [ORG_W-1:0] org_ff [3];
   logic [EXT_W-1:0]        ext_ff [3];
   logic [PLANE_W-1:0]      plane_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [SLOT_W-1:0] step_ff, step_in;

   // per-query split
   logic [BW-1:0]        base_ff [3];
   logic [FRAC_BITS-1:0] frac_ff [3];
   logic [BW-1:0]        base_in [3];
   logic [FRAC_BITS-1:0] frac_in [3];

   // fetch pipe
   logic               p1_vld_ff, p2_vld_ff;
   logic               p1_in_ff, p2_ok_ff;
   logic [SLOT_W-1:0]  p1_k_ff, p2_k_ff;
   logic [EXT_W-1:0]   p1_x_ff;
   logic [ROW_W-1:0]   p1_py_ff;
   logic [PZ_W-1:0]    p1_pz_ff;
   logic               s1_in;
   logic [EXT_W-1:0]   s1_c [3];
   logic [IDX_W-1:0]   s2_idx;
   logic               s2_ok;

   // corner slots and lerp
   logic [DENS_W-1:0]    slot_ff [8];
   logic                 slot_we;
   logic [SLOT_W-1:0]    slot_idx;
   logic [DENS_W-1:0]    slot_val;
   plan_type             plan;
   logic [FRAC_BITS-1:0] lerp_f;
   logic [DENS_W-1:0]    lerp_y;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DENS_W-1:0] rsp_data_ff, rsp_data_in;

   // store port
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [DENS_W-1:0] mem_wdata;
   logic [DENS_W-1:0] mem_rdata;
   logic [IDX_W-1:0]  wr_idx;
   logic              req_fire, wr_fire, wr_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_fire    = req_fire && (op_type'(req_tuser) == OP_WRITE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   //------------------------------------------------------------------
   // configuration registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         ext_ff[0] <= EXT_RESET;
         ext_ff[1] <= EXT_RESET;
         ext_ff[2] <= EXT_RESET;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_ORG_X: org_ff[0] <= csr_data;
            CSR_ORG_Y: org_ff[1] <= csr_data;
            CSR_ORG_Z: org_ff[2] <= csr_data;
            CSR_EXT_X: ext_ff[0] <= csr_data[EXT_W-1:0];
            CSR_EXT_Y: ext_ff[1] <= csr_data[EXT_W-1:0];
            CSR_EXT_Z: ext_ff[2] <= csr_data[EXT_W-1:0];
            default:   ;   // unknown index: drop
         endcase
      end
   end

   // plane pitch is registered from the extents, following them in the next cycle; settles before any fetch
   always_ff @(posedge clock) begin
      plane_ff <= {{(PLANE_W - EXT_W){1'b0}}, ext_ff[0]} *
                  {{(PLANE_W - EXT_W){1'b0}}, ext_ff[1]};
   end

   //------------------------------------------------------------------
   // position split: subtract origin and half a cell, then floor / fraction
   //------------------------------------------------------------------
   always_comb begin
      logic [POS_W-1:0] pos [3];
      logic [GW-1:0]    g;
      pos[0] = req_tdata[POSX_LSB +: POS_W];
      pos[1] = req_tdata[POSY_LSB +: POS_W];
      pos[2] = req_tdata[POSZ_LSB +: POS_W];
      for (int a = 0; a < 3; a++) begin
         g = {{(GW - POS_W){pos[a][POS_W-1]}}, pos[a]}
           - {{(GW - ORG_W - FRAC_BITS){org_ff[a][ORG_W-1]}}, org_ff[a], {FRAC_BITS{1'b0}}}
           - HALF_CELL;
         base_in[a] = g[GW-1:FRAC_BITS];
         frac_in[a] = g[FRAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (op_type'(req_tuser) == OP_SAMPLE)) begin
         base_ff <= base_in;
         frac_ff <= frac_in;
      end
   end

   //------------------------------------------------------------------
   // fetch stage 1: corner coordinates, grid check, row and plane products
   //------------------------------------------------------------------
   always_comb begin
      logic [BW:0] coord;
      s1_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         coord = {base_ff[a][BW-1], base_ff[a]} + {{BW{1'b0}}, cnt_ff[a]};
         s1_in = s1_in && !coord[BW] &&
                 (coord < {{(BW + 1 - EXT_W){1'b0}}, ext_ff[a]});
         s1_c[a] = coord[EXT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      p1_in_ff <= s1_in;
      p1_k_ff  <= cnt_ff[SLOT_W-1:0];
      p1_x_ff  <= s1_c[0];
      p1_py_ff <= {{(ROW_W - EXT_W){1'b0}}, s1_c[1]} *
                  {{(ROW_W - EXT_W){1'b0}}, ext_ff[0]};
      p1_pz_ff <= {{(PZ_W - EXT_W){1'b0}}, s1_c[2]} *
                  {{(PZ_W - PLANE_W){1'b0}}, plane_ff};
   end

   //------------------------------------------------------------------
   // fetch stage 2: flat index, store bound, read issue
   //------------------------------------------------------------------
   assign s2_idx = {{(IDX_W - EXT_W){1'b0}}, p1_x_ff}
                 + {{(IDX_W - ROW_W){1'b0}}, p1_py_ff}
                 + {{(IDX_W - PZ_W){1'b0}}, p1_pz_ff};
   assign s2_ok  = p1_in_ff && (s2_idx < CELL_LIMIT);

   always_ff @(posedge clock) begin
      p2_ok_ff <= s2_ok;
      p2_k_ff  <= p1_k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= (state_ff == ST_FETCH) && !cnt_ff[3];
         p2_vld_ff <= p1_vld_ff;
      end
   end

   //------------------------------------------------------------------
   // store port: writes from the request side, corner reads from the pipe
   //------------------------------------------------------------------
   assign wr_idx = {{(IDX_W - CELL_W){1'b0}}, req_tdata[CELL_LSB +: CELL_W]};
   assign wr_ok  = wr_fire && (wr_idx < CELL_LIMIT);

   always_comb begin
      mem_ctl.we = wr_ok;
      mem_ctl.en = wr_ok || p1_vld_ff;
      mem_addr   = wr_ok ? wr_idx[AW-1:0] : s2_idx[AW-1:0];
      // clamp to 1.0
      if (req_tdata[DENS_LSB +: DENS_W] > DENSITY_ONE) begin
         mem_wdata = DENSITY_ONE;
      end else begin
         mem_wdata = req_tdata[DENS_LSB +: DENS_W];
      end
   end

   tvs_store #(
      .DEPTH (MAX_CELLS),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   //------------------------------------------------------------------
   // lerp chain over the corner slots
   //------------------------------------------------------------------
   assign plan = lerp_plan(step_ff);

   always_comb begin
      case (plan.axis)
         AXIS_X:  lerp_f = frac_ff[0];
         AXIS_Y:  lerp_f = frac_ff[1];
         AXIS_Z:  lerp_f = frac_ff[2];
         default: lerp_f = '0;
      endcase
   end

   tvs_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .a (slot_ff[plan.a_slot]),
      .b (slot_ff[plan.b_slot]),
      .f (lerp_f),
      .y (lerp_y)
   );

   // corners land from the store; lerp results overwrite the lower slot
   always_comb begin
      slot_we  = 1'b0;
      slot_idx = p2_k_ff;
      slot_val = p2_ok_ff ? mem_rdata : '0;
      if (p2_vld_ff) begin
         slot_we = 1'b1;
      end else if ((state_ff == ST_LERP) && (step_ff != LAST_STEP)) begin
         slot_we  = 1'b1;
         slot_idx = plan.dst_slot;
         slot_val = lerp_y;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ff[slot_idx] <= slot_val;
      end
   end

   //------------------------------------------------------------------
   // sequencer
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (op_type'(req_tuser) == OP_SAMPLE)) begin
               state_in = ST_FETCH;
               cnt_in   = '0;
            end
         end
         ST_FETCH: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == FETCH_LAST) begin
               state_in = ST_LERP;
               step_in  = '0;
            end
         end
         ST_LERP: begin
            if (step_ff != LAST_STEP) begin
               step_in = step_ff + 3'd1;
            end else if (!rsp_valid_ff || rsp_tready) begin
               // hand over the final lerp
               rsp_valid_in = 1'b1;
               rsp_data_in  = lerp_y;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   //------------------------------------------------------------------
   // checks
   //------------------------------------------------------------------
   `ASSERT_NEVER(ast_port_clash, mem_ctl.we && p1_vld_ff, "store write collides with corner read")
   `ASSERT_ALWAYS(ast_pipe_in_fetch, p2_vld_ff |-> state_ff == ST_FETCH, "corner lands outside fetch")
   `ASSERT_ALWAYS(ast_lerp_drained, state_ff == ST_LERP |-> !p1_vld_ff && !p2_vld_ff, "lerp before fetch drained")
   `ASSERT_ALWAYS(ast_rsp_origin, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LERP && $past(step_ff) == LAST_STEP, "result without final lerp")

endmodule
